### rtl/stn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stn_pkg;

    // Characters that steer the normalizer.
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Depth of the result queue; it must take two words from one input.
    localparam int unsigned QUEUE_DEPTH = 4;

    // One input word.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } stn_in_t;

    // One result word.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       end_of_text;
    } stn_out_t;

endpackage

`default_nettype wire

### rtl/source_text_normalizer.sv
// An accepted word passes through the input register and then the result queue to the output.
// One input word per cycle while the queue has room; a word that yields two results is
// absorbed by a four-entry result queue.
// The input stalls while its register holds a word and the queue has fewer than two free entries.
// Reset (rst_n low, asynchronous) empties the pipeline and queue and returns the
// comment, string, escape, line-start, last-kept and held-space state to a new text.
`timescale 1ns / 1ps
`default_nettype none

module source_text_normalizer #(
    parameter int unsigned QueueDepth = stn_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            src_valid,
    output logic                 src_stall,
    input  wire stn_pkg::stn_in_t  src_word,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output stn_pkg::stn_out_t    res_word
);
    import stn_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    // Input register.
    logic    s_valid_reg, s_valid_next;
    stn_in_t s_word_reg;

    // Normalizer state.
    logic       comment_reg, comment_next;
    logic       str1_reg, str1_next;
    logic       esc1_reg, esc1_next;
    logic       str2_reg, str2_next;
    logic       esc2_reg, esc2_next;
    logic       line_start_reg, line_start_next;
    logic [7:0] last_kept_reg, last_kept_next;
    logic       held_reg, held_next;

    // Result queue.
    stn_out_t          queue_mem [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    logic       src_take;
    logic       advance;
    logic       pop;
    stn_out_t   res0, res1;
    logic [1:0] push_n;
    logic [7:0] c;
    logic       fin;
    logic       keep;
    logic       drop_held;
    logic       hold;

    // Handshake: the register moves on when the queue has room for two words.
    assign advance   = s_valid_reg && (count_reg <= CntW'(QueueDepth - 2));
    assign src_stall = s_valid_reg && !advance;
    assign src_take  = src_valid && !src_stall;
    assign pop       = res_valid && !res_stall;
    assign res_valid = (count_reg != '0);
    assign res_word  = queue_mem[rd_ptr_reg];

    // Both normalizing stages on the registered word.
    always_comb
    begin
        comment_next    = comment_reg;
        str1_next       = str1_reg;
        esc1_next       = esc1_reg;
        str2_next       = str2_reg;
        esc2_next       = esc2_reg;
        line_start_next = line_start_reg;
        last_kept_next  = last_kept_reg;
        held_next       = held_reg;
        res0            = '0;
        res1            = '0;
        push_n          = 2'd0;
        keep            = 1'b1;
        drop_held       = 1'b0;
        hold            = 1'b0;
        fin             = s_word_reg.final_byte;
        c               = s_word_reg.byte_in;

        // Comment blanking.
        if (esc1_reg)
        begin
            esc1_next = 1'b0;
        end
        else if (c == CH_SEMI && !str1_reg)
        begin
            comment_next = !comment_reg;
            c            = CH_SPACE;
        end
        else if (c == CH_NL)
        begin
            comment_next = 1'b0;
            str1_next    = 1'b0;
        end
        else if (comment_reg)
        begin
            c = CH_SPACE;
        end
        else if (c == CH_QUOTE)
        begin
            str1_next = !str1_reg;
        end
        else if (c == CH_BSLASH)
        begin
            esc1_next = 1'b1;
        end

        // White space normalization.
        if (esc2_reg)
        begin
            esc2_next = 1'b0;
        end
        else if (c == CH_QUOTE)
        begin
            str2_next = !str2_reg;
        end
        else if (c == CH_BSLASH)
        begin
            esc2_next = 1'b1;
        end
        else if (c == CH_NL)
        begin
            str2_next       = 1'b0;
            line_start_next = 1'b1;
            drop_held       = 1'b1;
        end
        else if (!str2_reg && c == CH_CR)
        begin
            keep = 1'b0;
        end
        else if (!str2_reg && c == CH_SPACE &&
                 (last_kept_reg == CH_SPACE || last_kept_reg == CH_COMMA ||
                  last_kept_reg == CH_PLUS || fin))
        begin
            keep = 1'b0;
        end
        else if (!str2_reg && c == CH_SPACE && line_start_reg)
        begin
            c               = CH_COMMA;
            line_start_next = 1'b0;
        end
        else if (!str2_reg && c == CH_SPACE)
        begin
            hold = 1'b1;
        end
        else if (!str2_reg && c == CH_PLUS)
        begin
            drop_held = 1'b1;
        end

        // Result words; a flushed held space goes first.
        if (hold)
        begin
            held_next      = 1'b1;
            last_kept_next = CH_SPACE;
        end
        else if (keep)
        begin
            held_next      = 1'b0;
            last_kept_next = c;
            if (held_reg && !drop_held)
            begin
                res0   = '{byte_out: CH_SPACE, byte_valid: 1'b1, end_of_text: 1'b0};
                res1   = '{byte_out: c, byte_valid: 1'b1, end_of_text: 1'b0};
                push_n = 2'd2;
            end
            else
            begin
                res0   = '{byte_out: c, byte_valid: 1'b1, end_of_text: 1'b0};
                push_n = 2'd1;
            end
        end

        // End of text: mark the last word and start a fresh text.
        if (fin)
        begin
            if (push_n == 2'd0)
            begin
                res0   = '{byte_out: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
                push_n = 2'd1;
            end
            else if (push_n == 2'd1)
            begin
                res0.end_of_text = 1'b1;
            end
            else
            begin
                res1.end_of_text = 1'b1;
            end
            comment_next    = 1'b0;
            str1_next       = 1'b0;
            esc1_next       = 1'b0;
            str2_next       = 1'b0;
            esc2_next       = 1'b0;
            line_start_next = 1'b1;
            last_kept_next  = CH_SPACE;
            held_next       = 1'b0;
        end
    end

    // Input register valid, queue pointers and fill count.
    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (src_take)
        begin
            s_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s_valid_next = 1'b0;
        end
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (advance)
        begin
            wr_ptr_next = wr_ptr_reg + PtrW'(push_n);
            count_next  = count_next + CntW'(push_n);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PtrW'(1);
            count_next  = count_next - CntW'(1);
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            comment_reg    <= 1'b0;
            str1_reg       <= 1'b0;
            esc1_reg       <= 1'b0;
            str2_reg       <= 1'b0;
            esc2_reg       <= 1'b0;
            line_start_reg <= 1'b1;
            last_kept_reg  <= CH_SPACE;
            held_reg       <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            if (advance)
            begin
                comment_reg    <= comment_next;
                str1_reg       <= str1_next;
                esc1_reg       <= esc1_next;
                str2_reg       <= str2_next;
                esc2_reg       <= esc2_next;
                line_start_reg <= line_start_next;
                last_kept_reg  <= last_kept_next;
                held_reg       <= held_next;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            s_word_reg <= src_word;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (advance && push_n != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (advance && push_n == 2'd2)
        begin
            queue_mem[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

    // The fill count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QueueDepth))
        else $error("result queue overfilled");

    // Pointers and fill count agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CntW'(QueueDepth)) ||
        ((wr_ptr_reg - rd_ptr_reg) == count_reg[PtrW-1:0]))
        else $error("queue pointers disagree with fill count");

    // A held space never exists inside a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> !str2_reg)
        else $error("space held inside a string");

    // The last word of a text leaves a fresh state behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s_word_reg.final_byte) |=>
            (!comment_reg && !held_reg && !esc1_reg && !esc2_reg && line_start_reg))
        else $error("state not cleared after end of text");

endmodule

`default_nettype wire

### sim/source_text_normalizer_tb.sv
`timescale 1ns / 1ps

module source_text_normalizer_tb;

    import stn_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 36;
    localparam int HOLD_CYCLES = 80;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_stall;
    stn_in_t  src_word;
    logic     res_valid;
    logic     res_stall;
    stn_out_t res_word;

    source_text_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    // Result words predicted but not yet seen, oldest first.
    stn_out_t expected_text[$];

    // Predicted state of the comment blanking stage.
    logic       comment_open;
    logic       in_string_blank;
    logic       escape_blank;
    // Predicted state of the white space stage.
    logic       in_string_space;
    logic       escape_space;
    logic       at_line_start;
    logic [7:0] last_kept_byte;
    logic       space_held;

    int  words_sent;
    int  texts_sent;
    int  results_seen;
    int  mismatches;
    int  cycle_count;
    bit  src_gaps_on;
    bit  res_gaps_on;
    bit  hold_request;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, expected_text.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Returns the predictor to the state of a fresh text.
    task automatic clear_text_state();
        comment_open    = 1'b0;
        in_string_blank = 1'b0;
        escape_blank    = 1'b0;
        in_string_space = 1'b0;
        escape_space    = 1'b0;
        at_line_start   = 1'b1;
        last_kept_byte  = CH_SPACE;
        space_held      = 1'b0;
    endtask

    // Works out the result words caused by one accepted input word.
    task automatic normalize_byte(input logic [7:0] raw, input logic fin);
        logic [7:0] c;
        logic       keep;
        logic       drop_held;
        logic       hold;
        stn_out_t   outs [2];
        int         n;
        c = raw;
        keep = 1'b1;
        drop_held = 1'b0;
        hold = 1'b0;
        n = 0;

        // Comment blanking.
        if (escape_blank)
            escape_blank = 1'b0;
        else if (raw == CH_SEMI && !in_string_blank)
        begin
            comment_open = ~comment_open;
            c = CH_SPACE;
        end
        else if (raw == CH_NL)
        begin
            comment_open = 1'b0;
            in_string_blank = 1'b0;
        end
        else if (comment_open)
            c = CH_SPACE;
        else if (raw == CH_QUOTE)
            in_string_blank = ~in_string_blank;
        else if (raw == CH_BSLASH)
            escape_blank = 1'b1;

        // White space folding.
        if (escape_space)
            escape_space = 1'b0;
        else if (c == CH_QUOTE)
            in_string_space = ~in_string_space;
        else if (c == CH_BSLASH)
            escape_space = 1'b1;
        else if (c == CH_NL)
        begin
            in_string_space = 1'b0;
            at_line_start = 1'b1;
            drop_held = 1'b1;
        end
        else if (!in_string_space && c == CH_CR)
            keep = 1'b0;
        else if (!in_string_space && c == CH_SPACE &&
                 (last_kept_byte == CH_SPACE || last_kept_byte == CH_COMMA ||
                  last_kept_byte == CH_PLUS || fin))
            keep = 1'b0;
        else if (!in_string_space && c == CH_SPACE && at_line_start)
        begin
            c = CH_COMMA;
            at_line_start = 1'b0;
        end
        else if (!in_string_space && c == CH_SPACE)
            hold = 1'b1;
        else if (!in_string_space && c == CH_PLUS)
            drop_held = 1'b1;

        if (hold)
        begin
            space_held = 1'b1;
            last_kept_byte = CH_SPACE;
        end
        else if (keep)
        begin
            if (space_held && !drop_held)
            begin
                outs[n] = '{byte_out: CH_SPACE, byte_valid: 1'b1, end_of_text: 1'b0};
                n++;
            end
            space_held = 1'b0;
            outs[n] = '{byte_out: c, byte_valid: 1'b1, end_of_text: 1'b0};
            n++;
            last_kept_byte = c;
        end

        // End of text closes with a marked word, empty if nothing was kept.
        if (fin)
        begin
            if (n == 0)
            begin
                outs[n] = '{byte_out: 8'h00, byte_valid: 1'b0, end_of_text: 1'b0};
                n++;
            end
            outs[n - 1].end_of_text = 1'b1;
            clear_text_state();
        end

        for (int i = 0; i < n; i++)
            expected_text = {expected_text, outs[i]};
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic check_result(input stn_out_t got);
        stn_out_t want;
        results_seen++;
        if (expected_text.size() == 0)
        begin
            note_failure($sformatf("unexpected word byte=%02h valid=%0b end=%0b",
                                   got.byte_out, got.byte_valid, got.end_of_text));
            return;
        end
        want = expected_text.pop_front();
        if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
            got.end_of_text !== want.end_of_text)
            note_failure($sformatf(
                "word %0d expected byte=%02h valid=%0b end=%0b, got byte=%02h valid=%0b end=%0b",
                results_seen, want.byte_out, want.byte_valid, want.end_of_text,
                got.byte_out, got.byte_valid, got.end_of_text));
    endtask

    // Receiver: checks accepted words and drives stall, including long holds.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (res_valid && !res_stall)
                    check_result(res_word);
                if (hold_request)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_request = 1'b0;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    res_stall <= 1'b1;
                end
                else
                    res_stall <= res_gaps_on && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Offers one word, with an optional random gap first, and waits until it is taken.
    task automatic send_word(input logic [7:0] b, input logic fin);
        if (src_gaps_on)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
        end
        src_valid <= 1'b1;
        src_word <= '{byte_in: b, final_byte: fin};
        do
            @(posedge clk);
        while (src_stall);
        normalize_byte(b, fin);
        words_sent++;
        if (fin)
            texts_sent++;
    endtask

    task automatic send_string(input string s, input logic fin_last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], fin_last && (i == s.len() - 1));
    endtask

    // Picks a byte weighted toward the characters that steer the block.
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'(8'h61 + $urandom_range(25));
        else if (r < 50)
            return CH_SPACE;
        else if (r < 55)
            return CH_COMMA;
        else if (r < 61)
            return CH_PLUS;
        else if (r < 68)
            return CH_SEMI;
        else if (r < 75)
            return CH_QUOTE;
        else if (r < 80)
            return CH_BSLASH;
        else if (r < 87)
            return CH_NL;
        else if (r < 92)
            return CH_CR;
        else
            return 8'($urandom_range(255));
    endfunction

    // Sends random texts until about count words have gone in.
    task automatic send_random_texts(input int count);
        int sent;
        int len;
        bit noise;
        bit open_end;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
            noise = ($urandom_range(9) == 0);
            open_end = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++)
                send_word(noise ? 8'($urandom_range(255)) : pick_text_byte(),
                          !open_end && (i == len - 1));
            sent += len;
        end
    endtask

    // Stops offering words and waits until every predicted word has arrived.
    task automatic wait_for_drain();
        src_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Space folding: line start comma, collapsed runs, a held space flushed before a byte.
    task automatic test_spacing();
        send_string("x  y z\n", 1'b0);
    endtask

    // Comments: held space dropped before a plus, comment blanking, newline ending it.
    task automatic test_comments();
        send_string("m r +;k\n", 1'b0);
    endtask

    // Strings and escapes, then the byte extremes with the last one ending the text.
    task automatic test_strings_and_escapes();
        send_string("\"; \\\"", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Held space and carriage return at end of text give an empty end word;
    // a backslash on the final byte leaves no pending escape.
    task automatic test_end_of_text();
        send_string("a b \r", 1'b1);
        send_word(CH_BSLASH, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_random_texts();
        src_gaps_on = 1'b1;
        res_gaps_on = 1'b1;
        send_random_texts(150);
    endtask

    // A run with no idling on either side.
    task automatic test_steady_stream();
        src_gaps_on = 1'b0;
        res_gaps_on = 1'b0;
        send_random_texts(60);
        wait_for_drain();
    endtask

    // The receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        res_gaps_on = 1'b0;
        hold_request = 1'b1;
        send_random_texts(30);
        wait_for_drain();
        src_gaps_on = 1'b1;
        res_gaps_on = 1'b1;
    endtask

    // Sequence of tests.
    initial
    begin
        rst_n <= 1'b0;
        src_valid <= 1'b0;
        src_word <= '0;
        res_stall <= 1'b0;
        words_sent = 0;
        texts_sent = 0;
        results_seen = 0;
        mismatches = 0;
        cycle_count = 0;
        src_gaps_on = 1'b1;
        res_gaps_on = 1'b1;
        hold_request = 1'b0;
        clear_text_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_spacing();
        test_comments();
        test_strings_and_escapes();
        test_end_of_text();
        test_random_texts();
        test_steady_stream();
        test_backpressure();
        test_random_texts();

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (expected_text.size() != 0)
            note_failure($sformatf("%0d predicted words never arrived", expected_text.size()));

        $display("Sent %0d input words in %0d texts, checked %0d result words, %0d mismatches.",
                 words_sent, texts_sent, results_seen, mismatches);
        $display("Covered comments, strings, escapes, space folding, end words and a long hold.");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
